FILE: hdl/bspline_curve_point_eval_top_assert.svh
// Assertion macros for the curve point evaluator.
// Each macro checks one implication on the rising edge of i_clk, with reset held off.
`ifndef BSPLINE_CURVE_POINT_EVAL_TOP_ASSERT_SVH
`define BSPLINE_CURVE_POINT_EVAL_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BSP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BSP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/bsp_pkg.sv
package bsp_pkg;

    localparam int CNT_W   = 7;    // point count register
    localparam int DEG_W   = 3;    // degree register
    localparam int KI_W    = 9;    // knot position index
    localparam int NUM_W   = 19;   // ratio numerator, below 7 * 2^16
    localparam int BAS_W   = 17;   // basis value, Q1.16 up to 1.0
    localparam int COORD_W = 32;
    localparam int ACC_W   = 52;
    localparam int REC_W   = 25;
    localparam int REC_SH  = 24;
    localparam int MA_W    = 33;
    localparam int MB_W    = 26;
    localparam int MP_W    = MA_W + MB_W;

    localparam logic [BAS_W-1:0] ONE_Q16 = 17'h10000;

    // Register indexes on the configuration port (address bit 2)
    localparam logic REG_DEGREE = 1'b0;
    localparam logic REG_COUNT  = 1'b1;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_EVAL = 1'b1
    } t_cmd;

    // floor(2^24 / s) for a knot span of s units
    function automatic logic [REC_W-1:0] recip(input logic [2:0] s);
        logic [REC_W-1:0] r;
        case (s)
            3'd1:    r = 25'd16777216;
            3'd2:    r = 25'd8388608;
            3'd3:    r = 25'd5592405;
            3'd4:    r = 25'd4194304;
            3'd5:    r = 25'd3355443;
            3'd6:    r = 25'd2796202;
            3'd7:    r = 25'd2396745;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Clamped uniform knot m, in whole units: clamp(m - p, 0, len)
    function automatic logic [CNT_W-1:0] knot_at(input logic [KI_W-1:0] m,
                                                 input logic [DEG_W-1:0] p,
                                                 input logic [CNT_W-1:0] len);
        logic [KI_W-1:0] d;
        if (m <= KI_W'(p)) begin
            return '0;
        end
        d = m - KI_W'(p);
        if (d >= KI_W'(len)) begin
            return len;
        end
        return d[CNT_W-1:0];
    endfunction

endpackage

FILE: hdl/bsp_mul.sv
module bsp_mul import bsp_pkg::*; (
    input  logic                   i_clk,
    input  logic signed [MA_W-1:0] i_a,
    input  logic signed [MB_W-1:0] i_b,
    output logic signed [MP_W-1:0] o_prod
);

    logic signed [MP_W-1:0] r_prod;

    // Register the product; the sequencer picks it up next cycle
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

FILE: hdl/bspline_curve_point_eval_top.sv
// Channel   | Direction | Handshake                  | Payload
// ----------+-----------+----------------------------+-------------------------------------
// input     | in        | i_in_valid / o_in_stall    | command, point_index, coord_x/y/z, t
// result    | out       | o_out_valid / i_out_stall  | point_x/y/z, bad_setup
// config    | in        | psel, penable, pwrite      | paddr, pwdata, prdata (pready high)
//
// A load transaction writes the store as it is accepted. An evaluate transaction
// scans the spans and builds a basis triangle for each of the up to p + 1 spans
// that hold t, using the shared multiplier four times per basis node.
// Reset (i_rst_n low, synchronous) idles the sequencer, clears o_out_valid, sets degree 3 and count 4.
// o_in_stall is high while an evaluation runs; a finished result waits in the
// output register, and loads are still taken while it waits.
`include "bspline_curve_point_eval_top_assert.svh"

module bspline_curve_point_eval_top import bsp_pkg::*; #(
    parameter int MAX_POINTS = 64,
    parameter int MAX_DEGREE = 7
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_command,
    input  logic [5:0]                i_point_index,
    input  logic signed [COORD_W-1:0] i_coord_x,
    input  logic signed [COORD_W-1:0] i_coord_y,
    input  logic signed [COORD_W-1:0] i_coord_z,
    input  logic [16:0]               i_t_param,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic signed [COORD_W-1:0] o_point_x,
    output logic signed [COORD_W-1:0] o_point_y,
    output logic signed [COORD_W-1:0] o_point_z,
    output logic                      o_bad_setup
);

    localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int SW   = (MAX_DEGREE > 0) ? $clog2(MAX_DEGREE + 1) : 1;
    localparam int SD   = 1 << SW;
    localparam int PCAP = (MAX_DEGREE > 7) ? 7 : MAX_DEGREE;
    localparam int NCAP = (MAX_POINTS > 127) ? 127 : MAX_POINTS;

    typedef enum logic [4:0] {
        S_IDLE, S_START, S_U, S_SPAN, S_INIT, S_NODE, S_LDIV, S_LFIX,
        S_RDIV, S_RFIX, S_LMUL, S_RMUL, S_WR, S_BASIS, S_AX, S_AY, S_AZ,
        S_ACC, S_DONE
    } t_state;

    typedef enum logic [1:0] {
        RC_ZERO, RC_ONE, RC_DIV
    } t_rcls;

    // Sequencer and configuration
    t_state             r_state;
    logic [DEG_W-1:0]   r_degree;
    logic [CNT_W-1:0]   r_count;
    logic [DEG_W-1:0]   r_p;
    logic [CNT_W-1:0]   r_n;
    logic [CNT_W-1:0]   r_i;
    logic [SW-1:0]      r_r;
    logic [SW-1:0]      r_j;
    logic               r_bad;
    logic               r_out_valid;
    logic               r_out_bad;

    // Working values
    logic [16:0]        r_t;
    logic [CNT_W-1:0]   r_q;
    logic [15:0]        r_f;
    logic [NUM_W-1:0]   r_lnum, r_rnum;
    logic [2:0]         r_ls, r_rs;
    t_rcls              r_lcls, r_rcls;
    logic [BAS_W-1:0]   r_lrat, r_rrat, r_lterm;
    logic signed [ACC_W-1:0] r_acc_x, r_acc_y, r_acc_z;
    logic signed [COORD_W-1:0] r_out_x, r_out_y, r_out_z;

    // Stores
    logic [3*COORD_W-1:0] r_mem [MAX_POINTS];
    logic [3*COORD_W-1:0] r_cp;
    logic [BAS_W-1:0]     r_scr [SD];
    logic [BAS_W-1:0]     r_rd0, r_rd1;

    // Combinational helpers
    logic                   in_accept, out_take, load_we;
    logic [DEG_W-1:0]       p_eff;
    logic [CNT_W-1:0]       n_eff, len;
    logic [KI_W-1:0]        base;
    logic [CNT_W-1:0]       k_a, k_a1, k_aj, k_aj1, k_ap1;
    logic signed [CNT_W:0]  dl, dr;
    logic [CNT_W-1:0]       sl_w, sr_w;
    t_rcls                  n_lcls, n_rcls;
    logic [NUM_W-1:0]       n_lnum, n_rnum;
    logic                   scr_we;
    logic [BAS_W-1:0]       scr_wd;
    logic [BAS_W:0]         node_sum;
    logic [BAS_W-1:0]       node_val;
    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic signed [MP_W-1:0] prod;
    logic signed [COORD_W-1:0] cp_x, cp_y, cp_z;

    // Correct a reciprocal quotient estimate by at most one
    function automatic logic [BAS_W-1:0] fix_quot(input logic signed [MP_W-1:0] pr,
                                                  input logic [NUM_W-1:0] num,
                                                  input logic [2:0] s);
        logic [NUM_W-1:0] qe, qs, rem;
        qe  = pr[REC_SH +: NUM_W];
        qs  = (s[0] ? qe : '0) + (s[1] ? {qe[NUM_W-2:0], 1'b0} : '0)
            + (s[2] ? {qe[NUM_W-3:0], 2'b0} : '0);
        rem = num - qs;
        if (rem >= NUM_W'(s)) begin
            qe = qe + NUM_W'(1);
        end
        return qe[BAS_W-1:0];
    endfunction

    // Floor to Q16.16 and clamp to the signed 32-bit range
    function automatic logic signed [COORD_W-1:0] sat_q16(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0] s;
        s = a >>> 16;
        if (s > $signed(ACC_W'(32'h7FFF_FFFF))) begin
            return 32'sh7FFF_FFFF;
        end
        if (s < -$signed(ACC_W'(33'h1_0000_0000) >>> 1)) begin
            return 32'sh8000_0000;
        end
        return s[COORD_W-1:0];
    endfunction

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_take  = r_out_valid && !i_out_stall;
    assign load_we   = in_accept && (i_command == CMD_LOAD)
                       && (11'(i_point_index) < 11'(MAX_POINTS));

    // Degree and count above the store limits act as the limits
    assign p_eff = (r_degree > DEG_W'(PCAP)) ? DEG_W'(PCAP) : r_degree;
    assign n_eff = (r_count > CNT_W'(NCAP)) ? CNT_W'(NCAP) : r_count;
    assign len   = r_n - CNT_W'(r_p);

    // Knots around the current node a = i + r
    assign base  = KI_W'(r_i) + KI_W'(r_r);
    assign k_a   = knot_at(base, r_p, len);
    assign k_a1  = knot_at(base + KI_W'(1), r_p, len);
    assign k_aj  = knot_at(base + KI_W'(r_j), r_p, len);
    assign k_aj1 = knot_at(base + KI_W'(r_j) + KI_W'(1), r_p, len);
    assign k_ap1 = knot_at(KI_W'(r_i) + KI_W'(r_p) + KI_W'(1), r_p, len);

    // Sort each ratio into zero, one, or a true division by the span
    always_comb begin
        dl     = $signed({1'b0, r_q}) - $signed({1'b0, k_a});
        sl_w   = k_aj - k_a;
        n_lnum = {dl[2:0], r_f};
        if (sl_w == '0 || dl < 0 || (dl == 0 && r_f == '0)) begin
            n_lcls = RC_ZERO;
        end else if (dl >= $signed({1'b0, sl_w})) begin
            n_lcls = RC_ONE;
        end else begin
            n_lcls = RC_DIV;
        end

        dr     = $signed({1'b0, k_aj1}) - $signed({1'b0, r_q});
        sr_w   = k_aj1 - k_a1;
        n_rnum = {dr[2:0], 16'h0000} - {3'b000, r_f};
        if (sr_w == '0 || dr <= 0) begin
            n_rcls = RC_ZERO;
        end else if (dr > $signed({1'b0, sr_w})
                     || (dr == $signed({1'b0, sr_w}) && r_f == '0)) begin
            n_rcls = RC_ONE;
        end else begin
            n_rcls = RC_DIV;
        end
    end

    // Basis node: sum of both weighted terms, capped at one
    assign node_sum = {1'b0, r_lterm} + {1'b0, prod[16 +: BAS_W]};
    assign node_val = (node_sum > {1'b0, ONE_Q16}) ? ONE_Q16 : node_sum[BAS_W-1:0];

    // Scratch writes: the indicator row first, then each node of the triangle
    always_comb begin
        scr_we = 1'b0;
        scr_wd = node_val;
        if (r_state == S_INIT) begin
            scr_we = 1'b1;
            scr_wd = (r_q >= k_a && r_q < k_a1) ? ONE_Q16 : '0;
        end else if (r_state == S_WR) begin
            scr_we = 1'b1;
        end
    end

    assign cp_x = r_cp[3*COORD_W-1:2*COORD_W];
    assign cp_y = r_cp[2*COORD_W-1:COORD_W];
    assign cp_z = r_cp[COORD_W-1:0];

    // Operand selection for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_START: begin
                mul_a = MA_W'(r_t);
                mul_b = MB_W'(len);
            end
            S_LDIV: begin
                mul_a = MA_W'(r_lnum);
                mul_b = MB_W'(recip(r_ls));
            end
            S_RDIV: begin
                mul_a = MA_W'(r_rnum);
                mul_b = MB_W'(recip(r_rs));
            end
            S_LMUL: begin
                mul_a = MA_W'(r_rd0);
                mul_b = MB_W'(r_lrat);
            end
            S_RMUL: begin
                mul_a = MA_W'(r_rd1);
                mul_b = MB_W'(r_rrat);
            end
            S_AX: begin
                mul_a = MA_W'(cp_x);
                mul_b = MB_W'(r_rd0);
            end
            S_AY: begin
                mul_a = MA_W'(cp_y);
                mul_b = MB_W'(r_rd0);
            end
            S_AZ: begin
                mul_a = MA_W'(cp_z);
                mul_b = MB_W'(r_rd0);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    bsp_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // Control point store: written by loads, read at the span being summed
    always_ff @(posedge i_clk) begin
        if (load_we) begin
            r_mem[AW'(i_point_index)] <= {i_coord_x, i_coord_y, i_coord_z};
        end
        r_cp <= r_mem[AW'(r_i)];
    end

    // Basis scratch: one write port, two registered read ports at r and r + 1
    always_ff @(posedge i_clk) begin
        if (scr_we) begin
            r_scr[r_r] <= scr_wd;
        end
        r_rd0 <= r_scr[r_r];
        r_rd1 <= r_scr[r_r + SW'(1)];
    end

    // Sequencer, configuration and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_degree    <= DEG_W'(3);
            r_count     <= CNT_W'(4);
            r_p         <= '0;
            r_n         <= '0;
            r_i         <= '0;
            r_r         <= '0;
            r_j         <= '0;
            r_bad       <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_bad   <= 1'b0;
        end else begin
            if (psel && penable && pwrite) begin
                if (paddr[2] == REG_DEGREE) begin
                    r_degree <= pwdata[DEG_W-1:0];
                end else begin
                    r_count <= pwdata[CNT_W-1:0];
                end
            end

            // the done state refills the result register itself
            if (out_take && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_accept && i_command == CMD_EVAL) begin
                        r_t     <= i_t_param;
                        r_p     <= p_eff;
                        r_n     <= n_eff;
                        r_bad   <= 1'b0;
                        r_acc_x <= '0;
                        r_acc_y <= '0;
                        r_acc_z <= '0;
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    // drop straight to the result on bad setup or t at or above one
                    if (r_n <= CNT_W'(r_p)) begin
                        r_bad   <= 1'b1;
                        r_state <= S_DONE;
                    end else if (r_t[16]) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_U;
                    end
                end
                S_U: begin
                    r_q     <= prod[16 +: CNT_W];
                    r_f     <= prod[15:0];
                    r_i     <= '0;
                    r_r     <= '0;
                    r_state <= S_SPAN;
                end
                S_SPAN: begin
                    if (r_i == r_n) begin
                        r_state <= S_DONE;
                    end else if (r_q >= k_a && r_q < k_ap1) begin
                        r_r     <= '0;
                        r_state <= S_INIT;
                    end else begin
                        r_i <= r_i + CNT_W'(1);
                    end
                end
                S_INIT: begin
                    if (4'(r_r) == 4'(r_p)) begin
                        r_r     <= '0;
                        r_j     <= SW'(1);
                        r_state <= (r_p == '0) ? S_BASIS : S_NODE;
                    end else begin
                        r_r <= r_r + SW'(1);
                    end
                end
                S_NODE: begin
                    r_lnum  <= n_lnum;
                    r_ls    <= sl_w[2:0];
                    r_lcls  <= n_lcls;
                    r_rnum  <= n_rnum;
                    r_rs    <= sr_w[2:0];
                    r_rcls  <= n_rcls;
                    r_state <= S_LDIV;
                end
                S_LDIV: begin
                    r_state <= S_LFIX;
                end
                S_LFIX: begin
                    case (r_lcls)
                        RC_ZERO: r_lrat <= '0;
                        RC_ONE:  r_lrat <= ONE_Q16;
                        default: r_lrat <= fix_quot(prod, r_lnum, r_ls);
                    endcase
                    r_state <= S_RDIV;
                end
                S_RDIV: begin
                    r_state <= S_RFIX;
                end
                S_RFIX: begin
                    case (r_rcls)
                        RC_ZERO: r_rrat <= '0;
                        RC_ONE:  r_rrat <= ONE_Q16;
                        default: r_rrat <= fix_quot(prod, r_rnum, r_rs);
                    endcase
                    r_state <= S_LMUL;
                end
                S_LMUL: begin
                    r_state <= S_RMUL;
                end
                S_RMUL: begin
                    r_lterm <= prod[16 +: BAS_W];
                    r_state <= S_WR;
                end
                S_WR: begin
                    // advance along the row, then to the next degree
                    if (4'(r_r) + 4'(r_j) == 4'(r_p)) begin
                        r_r <= '0;
                        if (4'(r_j) == 4'(r_p)) begin
                            r_state <= S_BASIS;
                        end else begin
                            r_j     <= r_j + SW'(1);
                            r_state <= S_NODE;
                        end
                    end else begin
                        r_r     <= r_r + SW'(1);
                        r_state <= S_NODE;
                    end
                end
                S_BASIS: begin
                    r_state <= S_AX;
                end
                S_AX: begin
                    r_state <= S_AY;
                end
                S_AY: begin
                    r_acc_x <= r_acc_x + ACC_W'(prod);
                    r_state <= S_AZ;
                end
                S_AZ: begin
                    r_acc_y <= r_acc_y + ACC_W'(prod);
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc_z <= r_acc_z + ACC_W'(prod);
                    r_i     <= r_i + CNT_W'(1);
                    r_state <= S_SPAN;
                end
                S_DONE: begin
                    // hold until the result register is free
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_x     <= sat_q16(r_acc_x);
                        r_out_y     <= sat_q16(r_acc_y);
                        r_out_z     <= sat_q16(r_acc_z);
                        r_out_bad   <= r_bad;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_point_x   = r_out_x;
    assign o_point_y   = r_out_y;
    assign o_point_z   = r_out_z;
    assign o_bad_setup = r_out_bad;
    assign pready      = 1'b1;
    assign prdata      = (paddr[2] == REG_COUNT) ? 32'(r_count) : 32'(r_degree);

    `BSP_ASSERT_NEXT(a_eval_starts, in_accept && i_command == CMD_EVAL, r_state == S_START, "evaluate transaction did not start the sequencer")
    `BSP_ASSERT_NOW(a_bad_is_origin, o_out_valid && o_bad_setup, o_point_x == 0 && o_point_y == 0 && o_point_z == 0, "bad setup result is not the origin")
    `BSP_ASSERT_NOW(a_ratio_cap, r_state == S_LMUL, r_lrat <= ONE_Q16 && r_rrat <= ONE_Q16, "basis ratio above one")
    `BSP_ASSERT_NOW(a_node_range, r_state == S_NODE, r_j != '0 && 4'(r_r) + 4'(r_j) <= 4'(r_p), "triangle node outside the degree")

endmodule

FILE: test/bspline_curve_point_eval_top_tb.sv
module bspline_curve_point_eval_top_tb;
    import bsp_pkg::*;

    localparam int N_SLOTS   = 64;
    localparam int DEG_LIMIT = 7;
    localparam longint ONE   = 65536;
    localparam longint CYCLE_LIMIT = 10000000;

    // Register byte addresses: degree at 0, count at 4
    localparam logic [2:0] ADDR_DEGREE = {REG_DEGREE, 2'b00};
    localparam logic [2:0] ADDR_COUNT  = {REG_COUNT, 2'b00};

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic               bad;
    } t_curve_point;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;
    logic i_in_valid;
    logic o_in_stall;
    logic i_command;
    logic [5:0] i_point_index;
    logic signed [31:0] i_coord_x, i_coord_y, i_coord_z;
    logic [16:0] i_t_param;
    logic o_out_valid;
    logic i_out_stall;
    logic signed [31:0] o_point_x, o_point_y, o_point_z;
    logic o_bad_setup;

    bspline_curve_point_eval_top dut (.*);

    // Predictor state
    longint ctrl_pts [N_SLOTS][3];
    bit     slot_loaded [N_SLOTS];
    int     deg_reg;
    int     count_reg;

    t_curve_point expected_points[$];
    int  errors = 0;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_off;
    longint cycle_count = 0;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Give up well past the slowest correct run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic longint knot_units(int m, int p, int len);
        int c;
        c = m - p;
        if (c < 0) c = 0;
        if (c > len) c = len;
        return longint'(c) * ONE;
    endfunction

    function automatic longint span_ratio(longint num, longint span);
        if (span <= 0 || num <= 0) return 0;
        if (num >= span) return ONE;
        return (num * ONE) / span;
    endfunction

    function automatic logic [31:0] clamp_q16(longint acc);
        longint f;
        f = acc >>> 16;
        if (f > 64'sd2147483647) f = 64'sd2147483647;
        if (f < -64'sd2147483648) f = -64'sd2147483648;
        return f[31:0];
    endfunction

    // Curve point at t from the current degree, count and control points
    function automatic t_curve_point eval_curve_point(int t);
        t_curve_point res;
        longint basis [DEG_LIMIT+1];
        longint acc [3];
        longint u, left, right, v;
        int p, n, len, a;
        p = (deg_reg > DEG_LIMIT) ? DEG_LIMIT : deg_reg;
        n = (count_reg > N_SLOTS) ? N_SLOTS : count_reg;
        res = '0;
        if (n <= p) begin
            res.bad = 1'b1;
            return res;
        end
        len = n - p;
        u = longint'(t) * len;
        for (int c = 0; c < 3; c++) acc[c] = 0;
        for (int i = 0; i < n; i++) begin
            if (!(u >= knot_units(i, p, len) && u < knot_units(i + p + 1, p, len)))
                continue;
            for (int r = 0; r <= p; r++)
                basis[r] = (u >= knot_units(i + r, p, len) &&
                            u < knot_units(i + r + 1, p, len)) ? ONE : 0;
            for (int j = 1; j <= p; j++) begin
                for (int r = 0; r <= p - j; r++) begin
                    a = i + r;
                    left = span_ratio(u - knot_units(a, p, len),
                                      knot_units(a + j, p, len) - knot_units(a, p, len));
                    right = span_ratio(knot_units(a + j + 1, p, len) - u,
                                       knot_units(a + j + 1, p, len) -
                                       knot_units(a + 1, p, len));
                    v = (basis[r] * left) / ONE + (basis[r + 1] * right) / ONE;
                    if (v > ONE) v = ONE;
                    basis[r] = v;
                end
            end
            for (int c = 0; c < 3; c++) acc[c] += ctrl_pts[i][c] * basis[0];
        end
        res.px = clamp_q16(acc[0]);
        res.py = clamp_q16(acc[1]);
        res.pz = clamp_q16(acc[2]);
        return res;
    endfunction

    // Offer one transaction, wait for acceptance, and predict on acceptance;
    // valid stays up for the next offer, and drain drops it
    task automatic send_item(logic cmd, logic [5:0] idx, logic [31:0] x, logic [31:0] y,
                             logic [31:0] z, logic [16:0] t);
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_command     <= cmd;
        i_point_index <= idx;
        i_coord_x     <= x;
        i_coord_y     <= y;
        i_coord_z     <= z;
        i_t_param     <= t;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (cmd == CMD_EVAL) begin
            expected_points = {expected_points, eval_curve_point(int'(t))};
        end else begin
            ctrl_pts[idx][0] = longint'(signed'(x));
            ctrl_pts[idx][1] = longint'(signed'(y));
            ctrl_pts[idx][2] = longint'(signed'(z));
            slot_loaded[idx] = 1'b1;
        end
    endtask

    task automatic load_point(int idx);
        send_item(CMD_LOAD, idx[5:0], $urandom, $urandom, $urandom, 17'($urandom));
    endtask

    task automatic eval_at(int t);
        send_item(CMD_EVAL, 6'($urandom), $urandom, $urandom, $urandom, t[16:0]);
    endtask

    // Drop valid, wait for every result, then let a full evaluation's worth of cycles pass
    task automatic drain;
        i_in_valid <= 1'b0;
        while (expected_points.size() != 0) @(posedge i_clk);
        repeat (2000) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] addr, int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        if (addr == ADDR_DEGREE) deg_reg = value & 7;
        else count_reg = value & 127;
    endtask

    task automatic set_curve(int p, int n);
        drain();
        write_reg(ADDR_DEGREE, p);
        write_reg(ADDR_COUNT, n);
    endtask

    // Load every slot so no evaluation reads an unwritten point
    task automatic test_fill_store;
        for (int i = 0; i < N_SLOTS; i++) load_point(i);
    endtask

    // Extremes of t, coordinates and degree, bad setup and oversize count
    task automatic test_directed;
        send_item(CMD_LOAD, 6'd0, 32'h7fffffff, 32'h80000000, 32'hffffffff, 17'h1ffff);
        send_item(CMD_LOAD, 6'd1, 32'h7fffffff, 32'h80000000, 32'h00000000, 17'h0);
        eval_at(0);
        eval_at(65535);
        eval_at(65536);
        eval_at(131071);
        eval_at(32768);
        set_curve(7, 8);
        eval_at(0);
        eval_at(40000);
        set_curve(1, 2);
        eval_at(20000);
        set_curve(3, 3);      // count not above degree
        eval_at(1000);
        set_curve(0, 5);      // piecewise constant
        eval_at(50000);
        set_curve(7, 127);    // count above the store
        eval_at(12345);
        eval_at(65535);
        set_curve(1, 64);
        eval_at(65535);
        send_item(CMD_LOAD, 6'd63, 32'h12345678, 32'hedcba987, 32'h0, 17'h0);
        eval_at(1);
    endtask

    // Mostly evaluations with the odd reload, under the current idling
    task automatic test_random(int count);
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(3, 0) == 0) load_point($urandom_range(63, 0));
            else if ($urandom_range(9, 0) == 0) eval_at($urandom_range(131071, 65536));
            else eval_at($urandom_range(65535, 0));
        end
    endtask

    task automatic test_random_configs;
        int p, n;
        for (int ph = 0; ph < 8; ph++) begin
            p = $urandom_range(7, 0);
            n = ($urandom_range(3, 0) == 0) ? $urandom_range(127, 2) : $urandom_range(12, 2);
            set_curve(p, n);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            test_random(50);
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    // Hold the result side off while offering items, wait until drained, then offer more
    task automatic test_backpressure;
        set_curve(2, 6);
        hold_off = 1'b1;
        fork
            begin
                test_random(30);
                drain();
            end
            begin
                repeat (600) @(posedge i_clk);
                hold_off = 1'b0;
            end
        join
        test_random(20);
    endtask

    // Result side: stall at random and compare each accepted result
    always @(posedge i_clk) begin
        t_curve_point want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_points.size() == 0) begin
                $display("%0t: unexpected result x=%h y=%h z=%h bad=%b", $time,
                         o_point_x, o_point_y, o_point_z, o_bad_setup);
                errors++;
            end else begin
                want = expected_points.pop_front();
                if (want.px !== o_point_x || want.py !== o_point_y ||
                    want.pz !== o_point_z || want.bad !== o_bad_setup) begin
                    $display("%0t: expected x=%h y=%h z=%h bad=%b, got x=%h y=%h z=%h bad=%b",
                             $time, want.px, want.py, want.pz, want.bad,
                             o_point_x, o_point_y, o_point_z, o_bad_setup);
                    errors++;
                end
            end
        end
        i_out_stall <= hold_off || (recv_stall_pct > 0 &&
                                    $urandom_range(99, 0) < recv_stall_pct);
    end

    initial begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 1'b0;
        deg_reg = 3;
        count_reg = 4;
        for (int i = 0; i < N_SLOTS; i++) begin
            slot_loaded[i] = 1'b0;
            for (int c = 0; c < 3; c++) ctrl_pts[i][c] = 0;
        end
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        i_in_valid = 1'b0; i_command = CMD_LOAD; i_point_index = '0;
        i_coord_x = '0; i_coord_y = '0; i_coord_z = '0; i_t_param = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_fill_store();
        test_directed();
        test_random_configs();
        test_backpressure();
        drain();
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/bsp_pkg.sv
hdl/bsp_mul.sv
hdl/bspline_curve_point_eval_top.sv
test/bspline_curve_point_eval_top_tb.sv
